>>> hw/rtl/tct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tct_pkg
// Shared types and constants for the touch contact tracker.
// ----------------------------------------------------------------------------
package tct_pkg;

    localparam logic [1:0] CMD_DOWN   = 2'd0;
    localparam logic [1:0] CMD_UP     = 2'd1;
    localparam logic [1:0] CMD_MOTION = 2'd2;
    localparam logic [1:0] CMD_QUERY  = 2'd3;

    localparam logic [1:0] REG_WW = 2'd0;
    localparam logic [1:0] REG_WH = 2'd1;
    localparam logic [1:0] REG_VW = 2'd2;
    localparam logic [1:0] REG_VH = 2'd3;

    localparam int          CFG_W   = 14;
    localparam int          IDX_W   = 8;
    localparam logic [12:0] VMAX    = 13'd8191;
    localparam logic [7:0]  PSCALE  = 8'd255;
    localparam int          DIV_W   = 40;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture item, start prep
        logic scan;      // walk one slot
        logic geom;      // compute geometry step
        logic div_start; // start a division
        logic [1:0] div_sel; // 0 offset, 1 x map, 2 y map
        logic commit;    // write table, build result
    } tct_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic div_done;
        logic is_place;
    } tct_stat_t;

endpackage : tct_pkg
`default_nettype wire

>>> hw/rtl/touch_contact_tracker_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// touch_contact_tracker_unit
// Touch contact slot table with letterboxed position mapping.
// ----------------------------------------------------------------------------
// Sequence: query/up/dropped events run the slot scan and then commit;
//   down/motion add three serial divisions (offset, x map, y map).
// Throughput: one transaction at a time; input stalls until the result is taken.
// Reset: async active low clears all slots, finger count and registers to
//   defaults (1920x1080 window, 640x480 virtual screen).
module touch_contact_tracker_unit #(
    parameter int SLOT_COUNT = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [13:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  command,
    input  wire logic [31:0] finger_id,
    input  wire logic [15:0] pos_x_frac,
    input  wire logic [15:0] pos_y_frac,
    input  wire logic [15:0] pressure_frac,
    input  wire logic [7:0]  touch_count,
    input  wire logic [7:0]  slot_index,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       slot_used,
    output logic             slot_found,
    output logic [12:0]      virt_x,
    output logic [12:0]      virt_y,
    output logic [7:0]       pressure_level,
    output logic             is_active,
    output logic [7:0]       finger_total
);
    import tct_pkg::*;

    tct_cmd_t  cmd;
    tct_stat_t stat;

    // sequence one transaction through scan, divide and commit
    tct_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd)
    );

    // hold table, geometry and the result register
    tct_datapath #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
        .command(command), .finger_id(finger_id), .pos_x_frac(pos_x_frac),
        .pos_y_frac(pos_y_frac), .pressure_frac(pressure_frac),
        .touch_count(touch_count), .slot_index(slot_index),
        .slot_used(slot_used), .slot_found(slot_found), .virt_x(virt_x),
        .virt_y(virt_y), .pressure_level(pressure_level),
        .is_active(is_active), .finger_total(finger_total)
    );

endmodule : touch_contact_tracker_unit
`default_nettype wire

>>> hw/rtl/tct_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tct_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tct_divider
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [tct_pkg::DIV_W-1:0] dividend,
    input  wire logic [tct_pkg::DIV_W-1:0] divisor,
    output logic                           done,
    output logic [tct_pkg::DIV_W-1:0]      quotient
);
    import tct_pkg::*;

    logic [DIV_W-1:0] q_reg, q_next;
    logic [DIV_W-1:0] r_reg, r_next;
    logic [DIV_W-1:0] d_reg, d_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = 6'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {r_reg, q_reg[DIV_W-1]} - {1'b0, d_reg};
            if (trial[DIV_W])
            begin
                r_next = {r_reg[DIV_W-2:0], q_reg[DIV_W-1]};
                q_next = {q_reg[DIV_W-2:0], 1'b0};
            end
            else
            begin
                r_next = trial[DIV_W-1:0];
                q_next = {q_reg[DIV_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule : tct_divider
`default_nettype wire

>>> hw/rtl/tct_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tct_datapath
// Slot table, slot search, letterbox geometry and result register.
// ----------------------------------------------------------------------------
module tct_datapath #(
    parameter int SLOT_COUNT = 16
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tct_pkg::tct_cmd_t   cmd,
    output tct_pkg::tct_stat_t       stat,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_idx,
    input  wire logic [13:0]         cfg_data,
    input  wire logic [1:0]          command,
    input  wire logic [31:0]         finger_id,
    input  wire logic [15:0]         pos_x_frac,
    input  wire logic [15:0]         pos_y_frac,
    input  wire logic [15:0]         pressure_frac,
    input  wire logic [7:0]          touch_count,
    input  wire logic [7:0]          slot_index,
    output logic [3:0]               slot_used,
    output logic                     slot_found,
    output logic [12:0]              virt_x,
    output logic [12:0]              virt_y,
    output logic [7:0]               pressure_level,
    output logic                     is_active,
    output logic [7:0]               finger_total
);
    import tct_pkg::*;

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);

    // configuration
    logic [13:0] ww_reg, wh_reg;
    logic [12:0] vw_reg, vh_reg;

    // slot table
    logic [SLOT_COUNT-1:0] act_reg;
    logic [31:0] fid_reg [SLOT_COUNT];
    logic [12:0] sx_reg  [SLOT_COUNT];
    logic [12:0] sy_reg  [SLOT_COUNT];
    logic [7:0]  sp_reg  [SLOT_COUNT];
    logic [7:0]  fcnt_reg;

    // captured item
    logic [1:0]  c_cmd_reg;
    logic [31:0] c_id_reg;
    logic [15:0] c_x_reg, c_y_reg, c_p_reg;
    logic [7:0]  c_cnt_reg, c_idx_reg;

    // search
    logic [CW-1:0] scan_reg;
    logic          hit_reg, free_ok_reg;
    logic [SW-1:0] hit_n_reg, free_n_reg;

    // geometry
    logic [13:0] ww, wh, vw, vh;
    logic [13:0] num_reg, den_reg;
    logic [24:0] off_reg;
    logic        off_neg_reg;
    logic        wide_reg;
    logic [27:0] a_reg, b_reg;
    logic [13:0] px_reg, py_reg;
    logic [7:0]  pr_reg;
    logic [12:0] mx_reg, my_reg;
    logic [39:0] div_a, div_b, div_q;
    logic        div_done;

    function automatic logic [13:0] clampr(input logic [13:0] v, input logic [13:0] hi);
        logic [13:0] r;
        r = v;
        if (v == 14'd0)
            r = 14'd1;
        else if (v > hi)
            r = hi;
        return r;
    endfunction

    assign ww = clampr(ww_reg, 14'd8192);
    assign wh = clampr(wh_reg, 14'd8192);
    assign vw = clampr({1'b0, vw_reg}, 14'd4096);
    assign vh = clampr({1'b0, vh_reg}, 14'd4096);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ww_reg <= 14'd1920;
            wh_reg <= 14'd1080;
            vw_reg <= 13'd640;
            vh_reg <= 13'd480;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_WW: ww_reg <= cfg_data;
                REG_WH: wh_reg <= cfg_data;
                REG_VW: vw_reg <= cfg_data[12:0];
                REG_VH: vh_reg <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // offset numerator magnitude; the sign is kept apart so the offset
    // truncates toward zero
    logic [27:0] off_num;
    assign off_num = (a_reg < b_reg) ? b_reg - a_reg : a_reg - b_reg;

    // mapping of a coordinate: clamp and subtract, then divide
    // a negative offset never clamps: the coordinate just shifts up
    logic [25:0] px_d, py_d;
    logic        px_lo, py_lo;
    logic [25:0] offx, offy;
    logic        negx, negy;
    assign offx = wide_reg ? {1'b0, off_reg} : 26'd0;
    assign offy = wide_reg ? 26'd0 : {1'b0, off_reg};
    assign negx = wide_reg & off_neg_reg;
    assign negy = !wide_reg & off_neg_reg;
    always_comb
    begin
        px_lo = !negx && (26'(px_reg) < offx);
        py_lo = !negy && (26'(py_reg) < offy);
        if (negx)
            px_d = 26'(px_reg) + offx;
        else
            px_d = ((26'(px_reg) > 26'(ww) - offx) ? 26'(ww) - offx : 26'(px_reg)) - offx;
        if (negy)
            py_d = 26'(py_reg) + offy;
        else
            py_d = ((26'(py_reg) > 26'(wh) - offy) ? 26'(wh) - offy : 26'(py_reg)) - offy;
    end

    always_comb
    begin
        div_a = '0;
        div_b = {26'd0, num_reg};
        unique case (cmd.div_sel)
            2'd0:    begin div_a = {12'd0, off_num}; div_b = {26'd0, den_reg}; end
            2'd1:    div_a = 40'(px_d) * 40'(den_reg);
            default: div_a = 40'(py_d) * 40'(den_reg);
        endcase
    end

    tct_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
        .dividend(div_a), .divisor(div_b), .done(div_done), .quotient(div_q)
    );

    function automatic logic [12:0] sat(input logic [39:0] q);
        return (q > 40'(VMAX)) ? VMAX : q[12:0];
    endfunction

    logic [SW-1:0] scan_idx;
    assign scan_idx = scan_reg[SW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            c_cmd_reg <= command;   c_id_reg  <= finger_id;
            c_x_reg   <= pos_x_frac; c_y_reg  <= pos_y_frac;
            c_p_reg   <= pressure_frac;
            c_cnt_reg <= touch_count; c_idx_reg <= slot_index;
            wide_reg  <= ww > wh;
            num_reg   <= (ww > wh) ? wh : ww;
            den_reg   <= (ww > wh) ? vh : vw;
        end
        if (cmd.geom)
        begin
            // offset numerator pieces; den*2 folded by halving after division
            a_reg  <= wide_reg ? 28'(ww) * 28'(vh) : 28'(wh) * 28'(vw);
            b_reg  <= wide_reg ? 28'(vw) * 28'(wh) : 28'(vh) * 28'(ww);
            px_reg <= 14'((32'(c_x_reg) * 32'(ww)) >> 16);
            py_reg <= 14'((32'(c_y_reg) * 32'(wh)) >> 16);
            pr_reg <= 8'((24'(c_p_reg) * 24'(PSCALE)) >> 16);
        end
        if (div_done)
        begin
            unique case (cmd.div_sel)
                2'd0:
                begin
                    off_reg     <= div_q[25:1];
                    off_neg_reg <= a_reg < b_reg;
                end
                2'd1:    mx_reg  <= px_lo ? 13'd0 : sat(div_q);
                default: my_reg  <= py_lo ? 13'd0 : sat(div_q);
            endcase
        end
    end

    logic [SW-1:0] sel_n;
    logic          sel_ok;
    always_comb
    begin
        if (c_cmd_reg == CMD_QUERY)
        begin
            sel_ok = c_idx_reg < 8'(SLOT_COUNT);
            sel_n  = c_idx_reg[SW-1:0];
        end
        else
        begin
            sel_ok = hit_reg | free_ok_reg;
            sel_n  = hit_reg ? hit_n_reg : free_n_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg  <= '0;
            fcnt_reg <= '0;
            scan_reg <= '0;
            hit_reg  <= 1'b0;
            free_ok_reg <= 1'b0;
            hit_n_reg <= '0;
            free_n_reg <= '0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                fid_reg[i] <= '0; sx_reg[i] <= '0; sy_reg[i] <= '0; sp_reg[i] <= '0;
            end
            slot_used <= '0; slot_found <= 1'b0; virt_x <= '0; virt_y <= '0;
            pressure_level <= '0; is_active <= 1'b0; finger_total <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                scan_reg <= '0; hit_reg <= 1'b0; free_ok_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                if (!hit_reg && act_reg[scan_idx] && fid_reg[scan_idx] == c_id_reg)
                begin
                    hit_reg <= 1'b1; hit_n_reg <= scan_idx;
                end
                if (!free_ok_reg && !act_reg[scan_idx])
                begin
                    free_ok_reg <= 1'b1; free_n_reg <= scan_idx;
                end
                scan_reg <= scan_reg + CW'(1);
            end
            if (cmd.commit)
            begin
                logic [7:0] fc;
                logic       a;
                logic [12:0] x, y;
                logic [7:0]  p;
                fc = (c_cmd_reg == CMD_UP || (c_cmd_reg == CMD_DOWN && sel_ok))
                     ? c_cnt_reg : fcnt_reg;
                a = act_reg[sel_n];
                x = sx_reg[sel_n]; y = sy_reg[sel_n]; p = sp_reg[sel_n];
                if (sel_ok)
                begin
                    unique case (c_cmd_reg)
                        CMD_DOWN:
                        begin
                            a = 1'b1; fid_reg[sel_n] <= c_id_reg;
                            x = mx_reg; y = my_reg; p = pr_reg;
                        end
                        CMD_MOTION:
                        begin
                            x = mx_reg; y = my_reg; p = pr_reg;
                        end
                        CMD_UP:
                        begin
                            a = 1'b0; p = 8'd0;
                        end
                        default: ;
                    endcase
                    act_reg[sel_n] <= a; sx_reg[sel_n] <= x;
                    sy_reg[sel_n] <= y; sp_reg[sel_n] <= p;
                end
                fcnt_reg       <= fc;
                finger_total   <= fc;
                slot_found     <= sel_ok;
                slot_used      <= sel_ok ? 4'(sel_n) : 4'd0;
                virt_x         <= sel_ok ? x : 13'd0;
                virt_y         <= sel_ok ? y : 13'd0;
                pressure_level <= sel_ok ? p : 8'd0;
                is_active      <= sel_ok ? a : 1'b0;
            end
        end
    end

    assign stat.scan_done = scan_reg == CW'(SLOT_COUNT);
    assign stat.div_done  = div_done;
    assign stat.is_place  = (c_cmd_reg == CMD_DOWN || c_cmd_reg == CMD_MOTION)
                            && (hit_reg || free_ok_reg);

endmodule : tct_datapath
`default_nettype wire

>>> hw/rtl/tct_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tct_ctrl
// Sequencer: capture, slot scan, geometry divisions, commit, output hold.
// ----------------------------------------------------------------------------
module tct_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    output logic                    out_valid,
    input  wire logic               out_stall,
    input  wire tct_pkg::tct_stat_t stat,
    output tct_pkg::tct_cmd_t       cmd
);
    import tct_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_GEOM, S_DIV, S_WAIT, S_COMMIT, S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] sel_reg, sel_next;

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.div_sel = sel_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            S_SCAN:
                if (stat.scan_done)
                    state_next = stat.is_place ? S_GEOM : S_COMMIT;
                else
                    cmd.scan = 1'b1;
            S_GEOM:
            begin
                cmd.geom   = 1'b1;
                sel_next   = 2'd0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT:
                if (stat.div_done)
                begin
                    if (sel_reg == 2'd2)
                        state_next = S_COMMIT;
                    else
                    begin
                        sel_next   = sel_reg + 2'd1;
                        state_next = S_DIV;
                    end
                end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
                if (!out_stall)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = state_reg == S_OUT;

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("input taken while result pending");
    a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid) else $error("commit without result");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid) else $error("result dropped");

endmodule : tct_ctrl
`default_nettype wire

>>> tb/touch_contact_tracker_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_contact_tracker_unit_test
// Drives finger down, up, motion and query transactions into the contact
// tracker under several window and virtual screen settings. A local model of
// the slot table predicts each result, and every returned result is compared
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module touch_contact_tracker_unit_test;
    import tct_pkg::*;

    localparam int SLOTS      = 16;
    localparam int WATCH_MAX  = 20000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [13:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  command;
    logic [31:0] finger_id;
    logic [15:0] pos_x_frac;
    logic [15:0] pos_y_frac;
    logic [15:0] pressure_frac;
    logic [7:0]  touch_count;
    logic [7:0]  slot_index;
    logic        out_valid;
    logic        out_stall;
    logic [3:0]  slot_used;
    logic        slot_found;
    logic [12:0] virt_x;
    logic [12:0] virt_y;
    logic [7:0]  pressure_level;
    logic        is_active;
    logic [7:0]  finger_total;

    touch_contact_tracker_unit #(.SLOT_COUNT(SLOTS)) dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .finger_id(finger_id),
        .pos_x_frac(pos_x_frac), .pos_y_frac(pos_y_frac),
        .pressure_frac(pressure_frac), .touch_count(touch_count),
        .slot_index(slot_index),
        .out_valid(out_valid), .out_stall(out_stall),
        .slot_used(slot_used), .slot_found(slot_found),
        .virt_x(virt_x), .virt_y(virt_y), .pressure_level(pressure_level),
        .is_active(is_active), .finger_total(finger_total)
    );

    typedef struct packed {
        logic [3:0]  used;
        logic        found;
        logic [12:0] vx;
        logic [12:0] vy;
        logic [7:0]  press;
        logic        act;
        logic [7:0]  total;
    } contact_report_t;

    // Local copy of the slot table and registers
    logic        tbl_active [SLOTS];
    logic [31:0] tbl_finger [SLOTS];
    logic [12:0] tbl_x      [SLOTS];
    logic [12:0] tbl_y      [SLOTS];
    logic [7:0]  tbl_press  [SLOTS];
    logic [7:0]  tbl_count;
    logic [13:0] reg_ww, reg_wh, reg_vw, reg_vh;

    contact_report_t pending_reports[$];
    int  mismatches = 0;
    int  results_seen = 0;
    int  sent_items = 0;
    int  idle_cycles = 0;
    int  cfg_settings = 0;
    bit  hold_receiver = 0;
    bit  burst_mode = 1;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic longint clamp_reg(input longint v, input longint hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [12:0] letterbox(input longint p, input longint lo,
                                              input longint hi, input longint num,
                                              input longint den);
        longint q;
        if (p < lo) return 13'd0;
        if (p > hi) p = hi;
        if (p - lo < 0) return 13'd0;
        q = ((p - lo) * den) / num;
        if (q > 8191) q = 8191;
        return q[12:0];
    endfunction

    function automatic void store_position(input int n, input logic [15:0] fx,
                                           input logic [15:0] fy,
                                           input logic [15:0] fp);
        longint ww, wh, vw, vh, num, den, offx, offy, px, py;
        ww = clamp_reg(reg_ww, 8192);
        wh = clamp_reg(reg_wh, 8192);
        vw = clamp_reg(reg_vw, 4096);
        vh = clamp_reg(reg_vh, 4096);
        if (ww > wh)
        begin
            num = wh; den = vh;
            offx = (ww * vh - vw * wh) / (2 * vh);
            offy = 0;
        end
        else
        begin
            num = ww; den = vw;
            offx = 0;
            offy = (wh * vw - vh * ww) / (2 * vw);
        end
        px = (longint'(fx) * ww) >>> 16;
        py = (longint'(fy) * wh) >>> 16;
        tbl_press[n] = 8'((longint'(fp) * 255) >>> 16);
        tbl_x[n] = letterbox(px, offx, ww - offx, num, den);
        tbl_y[n] = letterbox(py, offy, wh - offy, num, den);
    endfunction

    function automatic int pick_slot(input logic [31:0] id);
        for (int n = 0; n < SLOTS; n++)
            if (tbl_active[n] && tbl_finger[n] == id) return n;
        for (int n = 0; n < SLOTS; n++)
            if (!tbl_active[n]) return n;
        return -1;
    endfunction

    function automatic contact_report_t track_contact(
        input logic [1:0] cmd, input logic [31:0] id, input logic [15:0] fx,
        input logic [15:0] fy, input logic [15:0] fp, input logic [7:0] cnt,
        input logic [7:0] idx);
        contact_report_t r;
        int n;
        if (cmd == CMD_QUERY)
            n = (idx < SLOTS) ? int'(idx) : -1;
        else
        begin
            n = pick_slot(id);
            if (cmd == CMD_UP) tbl_count = cnt;
            if (n >= 0)
            begin
                case (cmd)
                    CMD_DOWN:
                    begin
                        tbl_count = cnt;
                        tbl_finger[n] = id;
                        tbl_active[n] = 1'b1;
                        store_position(n, fx, fy, fp);
                    end
                    CMD_MOTION: store_position(n, fx, fy, fp);
                    default:
                    begin
                        tbl_active[n] = 1'b0;
                        tbl_press[n] = 8'd0;
                    end
                endcase
            end
        end
        r = '0;
        if (n >= 0)
        begin
            r.used  = 4'(n);
            r.found = 1'b1;
            r.vx    = tbl_x[n];
            r.vy    = tbl_y[n];
            r.press = tbl_press[n];
            r.act   = tbl_active[n];
        end
        r.total = tbl_count;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Shared driving tasks
    // ------------------------------------------------------------------
    task automatic send_event(input logic [1:0] cmd, input logic [31:0] id,
                              input logic [15:0] fx, input logic [15:0] fy,
                              input logic [15:0] fp, input logic [7:0] cnt,
                              input logic [7:0] idx);
        // Hold the transaction until the block takes it
        in_valid      <= 1'b1;
        command       <= cmd;
        finger_id     <= id;
        pos_x_frac    <= fx;
        pos_y_frac    <= fy;
        pressure_frac <= fp;
        touch_count   <= cnt;
        slot_index    <= idx;
        do @(posedge clk); while (in_stall);
        pending_reports.push_back(track_contact(cmd, id, fx, fy, fp, cnt, idx));
        sent_items++;
        // Insert a random gap between bursts
        if (burst_mode && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
        // Let a dropped or still-running event settle before touching registers
        repeat (SLOTS + 140) @(posedge clk);
    endtask

    task automatic write_settings(input logic [13:0] ww, input logic [13:0] wh,
                                  input logic [13:0] vw, input logic [13:0] vh);
        logic [13:0] vals [4];
        vals = '{ww, wh, vw, vh};
        drain_results();
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        reg_ww = ww;
        reg_wh = wh;
        reg_vw = 14'(vw[12:0]);
        reg_vh = 14'(vh[12:0]);
        cfg_settings++;
    endtask

    // Biased finger IDs so that matches are common, with a full-range tail
    function automatic logic [31:0] pick_finger();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return 32'hFFFF_FFF0 | 32'($urandom_range(0, 15));
            default: return 32'($urandom_range(0, 19));
        endcase
    endfunction

    task automatic send_random(input int count);
        logic [1:0] cmd;
        for (int i = 0; i < count; i++)
        begin
            cmd = 2'($urandom_range(0, 3));
            send_event(cmd, pick_finger(), 16'($urandom()), 16'($urandom()),
                       16'($urandom()), 8'($urandom()),
                       ($urandom_range(0, 3) == 0) ? 8'($urandom())
                                                   : 8'($urandom_range(0, 15)));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        // Empty table, full-range fields, and every command
        send_event(CMD_QUERY, 32'h0, 16'h0, 16'h0, 16'h0, 8'h0, 8'd0);
        send_event(CMD_DOWN, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
        send_event(CMD_DOWN, 32'h0, 16'h0, 16'h0, 16'h0, 8'h01, 8'h00);
        send_event(CMD_MOTION, 32'hFFFF_FFFF, 16'h8000, 16'h8000, 16'h8000, 8'h0, 8'h0);
        send_event(CMD_MOTION, 32'h1234_5678, 16'h4000, 16'hC000, 16'h1, 8'h0, 8'h0);
        send_event(CMD_UP, 32'h0, 16'h0, 16'h0, 16'h0, 8'hAA, 8'h0);
        send_event(CMD_UP, 32'h5555_5555, 16'h0, 16'h0, 16'h0, 8'h55, 8'h0);
        send_event(CMD_QUERY, 32'h0, 16'h0, 16'h0, 16'h0, 8'h0, 8'd15);
        send_event(CMD_QUERY, 32'h0, 16'h0, 16'h0, 16'h0, 8'h0, 8'd16);
        send_event(CMD_QUERY, 32'h0, 16'h0, 16'h0, 16'h0, 8'h0, 8'd255);
        // Fill the table, then overflow it so the last downs are dropped
        for (int i = 0; i < SLOTS + 1; i++)
            send_event(CMD_DOWN, 32'(100 + i), 16'(i * 4000), 16'(i * 3000),
                       16'(i * 4096), 8'(i), 8'h0);
        send_event(CMD_MOTION, 32'd999, 16'h1, 16'h1, 16'h1, 8'h0, 8'h0);
        send_event(CMD_UP, 32'd999, 16'h0, 16'h0, 16'h0, 8'h7, 8'h0);
    endtask

    task automatic test_settings_sweep();
        // Extremes, zero registers (clamped), tall and wide windows
        logic [13:0] table_set [7][4];
        table_set = '{'{14'd8192, 14'd1, 14'd1, 14'd4096},
                      '{14'd1, 14'd8192, 14'd4096, 14'd1},
                      '{14'd0, 14'd0, 14'd0, 14'd0},
                      '{14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF},
                      '{14'd1080, 14'd1920, 14'd480, 14'd640},
                      '{14'd8192, 14'd8192, 14'd1, 14'd1},
                      '{14'd1920, 14'd1080, 14'd640, 14'd480}};
        for (int s = 0; s < 7; s++)
        begin
            write_settings(table_set[s][0], table_set[s][1], table_set[s][2],
                           table_set[s][3]);
            send_random(60);
        end
    endtask

    task automatic test_random_settings();
        for (int s = 0; s < 6; s++)
        begin
            write_settings(14'($urandom_range(1, 8192)), 14'($urandom_range(1, 8192)),
                           14'($urandom_range(1, 4096)), 14'($urandom_range(1, 4096)));
            send_random(200);
        end
    endtask

    task automatic test_backpressure();
        // Hold the receiver off while offering items so the input stalls
        burst_mode = 0;
        hold_receiver = 1;
        send_random(30);
        hold_receiver = 0;
        burst_mode = 1;
        // Pause the sender until everything has come back
        in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
        send_random(120);
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall pattern, long hold-off, and result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got %0d, expected %0d (result %0d)",
                 what, got, want, results_seen);
        mismatches++;
    endtask

    initial
    begin
        int phase;
        out_stall = 1'b0;
        phase = 0;
        forever
        begin
            @(posedge clk);
            if (hold_receiver)
            begin
                out_stall <= 1'b1;
                repeat (800) @(posedge clk);
                out_stall <= 1'b0;
                wait (!hold_receiver);
            end
            else
            begin
                phase = (phase + 1) % 64;
                out_stall <= (phase < 32) ? ($urandom_range(0, 2) == 0) : 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        contact_report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_reports.size() == 0)
            begin
                $display("unexpected result %0d", results_seen);
                mismatches++;
            end
            else
            begin
                want = pending_reports.pop_front();
                if (slot_used != want.used) report_mismatch("slot_used", slot_used, want.used);
                if (slot_found != want.found) report_mismatch("slot_found", slot_found, want.found);
                if (virt_x != want.vx) report_mismatch("virt_x", virt_x, want.vx);
                if (virt_y != want.vy) report_mismatch("virt_y", virt_y, want.vy);
                if (pressure_level != want.press)
                    report_mismatch("pressure_level", pressure_level, want.press);
                if (is_active != want.act) report_mismatch("is_active", is_active, want.act);
                if (finger_total != want.total)
                    report_mismatch("finger_total", finger_total, want.total);
            end
        end
    end

    // Watchdog: advance a counter on cycles with no accepted input, taken result or register write
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCH_MAX)
        begin
            $display("touch_contact_tracker_unit_test NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = REG_WW; cfg_data = '0;
        in_valid = 1'b0; command = CMD_QUERY; finger_id = '0;
        pos_x_frac = '0; pos_y_frac = '0; pressure_frac = '0;
        touch_count = '0; slot_index = '0;
        for (int n = 0; n < SLOTS; n++)
        begin
            tbl_active[n] = 1'b0; tbl_finger[n] = '0;
            tbl_x[n] = '0; tbl_y[n] = '0; tbl_press[n] = '0;
        end
        tbl_count = '0;
        reg_ww = 14'd1920; reg_wh = 14'd1080; reg_vw = 14'd640; reg_vh = 14'd480;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_settings_sweep();
        test_random_settings();

        in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
        repeat (SLOTS + 140) @(posedge clk);

        $display("covered %0d events and %0d results over %0d register settings,",
                 sent_items, results_seen, cfg_settings);
        $display("including a full table, dropped events and out-of-range queries");
        if (mismatches == 0)
            $display("touch_contact_tracker_unit_test OK");
        else
            $display("touch_contact_tracker_unit_test NOT OK");
        $finish;
    end
endmodule
